// ===== hdl/ptw_pkg.sv =====
// Shared types, codes and helpers of the four-level page-table walker.
// Used by the request/response interfaces, the table store and the top level.
package ptw_pkg;

	localparam int FRAME_COUNT_DEF = 16;
	localparam int ENTRY_W         = 64;
	localparam int VA_W            = 64;
	localparam int PA_W            = 52;
	localparam int IN_FRAME_W      = 4;
	localparam int INDEX_W         = 9;
	localparam int TABLE_FRAME_W   = 40;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	localparam logic REG_ROOT_FRAME = 1'b0;

	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_NONCANON = 2'd1;
	localparam logic [1:0] FAULT_UNMAPPED = 2'd2;
	localparam logic [1:0] FAULT_FRAME    = 2'd3;

	localparam logic [1:0] SIZE_NONE = 2'd0;
	localparam logic [1:0] SIZE_4K   = 2'd1;
	localparam logic [1:0] SIZE_2M   = 2'd2;
	localparam logic [1:0] SIZE_1G   = 2'd3;

	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} ptw_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ptw_mem_ctl_t;

	function automatic logic [INDEX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [INDEX_W-1:0] idx;
		case (lvl)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

// ===== hdl/ptw_ifs.sv =====
// Request and response channel interfaces of the page-table walker.
// Depends on ptw_pkg for the field widths.
interface ptw_req_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic [ptw_pkg::IN_FRAME_W-1:0]     entry_frame;
	logic [ptw_pkg::INDEX_W-1:0]        entry_index;
	logic [ptw_pkg::ENTRY_W-1:0]        entry_value;
	logic [ptw_pkg::VA_W-1:0]           virtual_address;

	modport source (output valid, opcode, entry_frame, entry_index, entry_value,
		virtual_address, input ready);
	modport sink (input valid, opcode, entry_frame, entry_index, entry_value,
		virtual_address, output ready);
endinterface

interface ptw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        translated;
	logic [1:0]                  fault_code;
	logic [ptw_pkg::PA_W-1:0]    physical_address;
	logic [1:0]                  page_size_code;

	modport source (output valid, translated, fault_code, physical_address,
		page_size_code, input ready);
	modport sink (input valid, translated, fault_code, physical_address,
		page_size_code, output ready);
endinterface

// ===== hdl/four_level_page_table_walker.sv =====
// Top level of the four-level page-table walker: control FSM, APB register
// and response register. Depends on ptw_pkg, ptw_ifs and ptw_table.
//
//  Channel   Direction  Handshake        Carries
//  req       in         valid/ready      one write or translate request
//  rsp       out        valid/ready      one result for every request
//  apb       in/out     psel/penable     root_frame register
//
// A write request's result passes through the pending and response registers;
// a translation first makes one dependent table read per level walked on the
// single read port, then completes through the same registers.
// After reset a clearing sweep zeroes all FRAME_COUNT*512 entries of the store
// at one entry a cycle, while no request is accepted.
// A new request is accepted while a finished result waits in the response
// register; completion stalls only while that register is still full.
module four_level_page_table_walker #(
	parameter int FRAME_COUNT = ptw_pkg::FRAME_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ptw_req_if.sink                       req,
	ptw_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptw_pkg::PADDR_W-1:0]   paddr,
	input  logic [ptw_pkg::PDATA_W-1:0]   pwdata,
	output logic [ptw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int AW = $clog2(FRAME_COUNT * 512);

	ptw_pkg::ptw_state_t state_q, state_d;

	logic [ptw_pkg::IN_FRAME_W-1:0] root_frame_q;
	logic [ptw_pkg::VA_W-1:0]       va_q;
	logic [1:0]                     level_q, level_d;
	logic                           level_load;

	logic                           pend_load;
	logic                           pend_ok_q, pend_ok_d;
	logic [1:0]                     pend_fault_q, pend_fault_d;
	logic [ptw_pkg::PA_W-1:0]       pend_pa_q, pend_pa_d;
	logic [1:0]                     pend_size_q, pend_size_d;

	logic                           rsp_valid_q;
	logic                           rsp_load;
	logic                           rsp_ok_q;
	logic [1:0]                     rsp_fault_q;
	logic [ptw_pkg::PA_W-1:0]       rsp_pa_q;
	logic [1:0]                     rsp_size_q;

	ptw_pkg::ptw_mem_ctl_t          mem_ctl;
	logic [AW-1:0]                  wr_addr;
	logic [AW-1:0]                  rd_addr;
	logic [ptw_pkg::ENTRY_W-1:0]    entry;
	logic                           clr_busy;

	logic                           accept;
	logic                           canonical;
	logic [ptw_pkg::TABLE_FRAME_W-1:0] wr_frame;
	logic [ptw_pkg::TABLE_FRAME_W-1:0] rd_frame;
	logic [ptw_pkg::INDEX_W-1:0]       rd_index;
	logic                              cfg_wr;

	ptw_table #(
		.FRAME_COUNT (FRAME_COUNT),
		.AW          (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (req.entry_value),
		.rd_addr (rd_addr),
		.rd_data (entry),
		.busy    (clr_busy)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ptw_pkg::REG_ROOT_FRAME) ?
		ptw_pkg::PDATA_W'(root_frame_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (cfg_wr && paddr[2] == ptw_pkg::REG_ROOT_FRAME) begin
			root_frame_q <= pwdata[ptw_pkg::IN_FRAME_W-1:0];
		end
	end

	assign req.ready = (state_q == ptw_pkg::ST_IDLE) && !clr_busy;
	assign accept    = req.valid && req.ready;
	assign canonical = (&req.virtual_address[63:47]) || !(|req.virtual_address[63:47]);
	assign wr_frame  = ptw_pkg::TABLE_FRAME_W'(req.entry_frame);
	assign wr_addr   = AW'({wr_frame[FW-1:0], req.entry_index});
	assign rd_addr   = AW'({rd_frame[FW-1:0], rd_index});

	always_comb begin
		state_d      = state_q;
		level_d      = level_q;
		level_load   = 1'b0;
		mem_ctl      = '0;
		rd_frame     = ptw_pkg::TABLE_FRAME_W'(root_frame_q);
		rd_index     = ptw_pkg::lvl_index(req.virtual_address, ptw_pkg::LVL_PML4);
		pend_load    = 1'b0;
		pend_ok_d    = 1'b0;
		pend_fault_d = ptw_pkg::FAULT_NONE;
		pend_pa_d    = '0;
		pend_size_d  = ptw_pkg::SIZE_NONE;
		rsp_load     = 1'b0;
		case (state_q)
			ptw_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.opcode == ptw_pkg::OP_WRITE) begin
						mem_ctl.wr_en = 32'(req.entry_frame) < FRAME_COUNT;
						pend_load     = 1'b1;
						state_d       = ptw_pkg::ST_DONE;
					end else if (!canonical) begin
						pend_load    = 1'b1;
						pend_fault_d = ptw_pkg::FAULT_NONCANON;
						state_d      = ptw_pkg::ST_DONE;
					end else if (32'(root_frame_q) >= FRAME_COUNT) begin
						pend_load    = 1'b1;
						pend_fault_d = ptw_pkg::FAULT_FRAME;
						state_d      = ptw_pkg::ST_DONE;
					end else begin
						mem_ctl.rd_en = 1'b1;
						level_d       = ptw_pkg::LVL_PML4;
						level_load    = 1'b1;
						state_d       = ptw_pkg::ST_WALK;
					end
				end
			end
			ptw_pkg::ST_WALK: begin
				rd_frame = entry[51:12];
				rd_index = ptw_pkg::lvl_index(va_q, level_q + 2'd1);
				if (!entry[ptw_pkg::BIT_PRESENT]) begin
					pend_load    = 1'b1;
					pend_fault_d = ptw_pkg::FAULT_UNMAPPED;
					state_d      = ptw_pkg::ST_DONE;
				end else if (level_q == ptw_pkg::LVL_PDPT && entry[ptw_pkg::BIT_LARGE]) begin
					pend_load   = 1'b1;
					pend_ok_d   = 1'b1;
					pend_pa_d   = {entry[51:30], va_q[29:0]};
					pend_size_d = ptw_pkg::SIZE_1G;
					state_d     = ptw_pkg::ST_DONE;
				end else if (level_q == ptw_pkg::LVL_PD && entry[ptw_pkg::BIT_LARGE]) begin
					pend_load   = 1'b1;
					pend_ok_d   = 1'b1;
					pend_pa_d   = {entry[51:21], va_q[20:0]};
					pend_size_d = ptw_pkg::SIZE_2M;
					state_d     = ptw_pkg::ST_DONE;
				end else if (level_q == ptw_pkg::LVL_PT) begin
					pend_load   = 1'b1;
					pend_ok_d   = 1'b1;
					pend_pa_d   = {entry[51:12], va_q[11:0]};
					pend_size_d = ptw_pkg::SIZE_4K;
					state_d     = ptw_pkg::ST_DONE;
				end else if (entry[51:12] >= ptw_pkg::TABLE_FRAME_W'(FRAME_COUNT)) begin
					pend_load    = 1'b1;
					pend_fault_d = ptw_pkg::FAULT_FRAME;
					state_d      = ptw_pkg::ST_DONE;
				end else begin
					mem_ctl.rd_en = 1'b1;
					level_d       = level_q + 2'd1;
					level_load    = 1'b1;
				end
			end
			ptw_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ptw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptw_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= req.virtual_address;
		end
		if (level_load) begin
			level_q <= level_d;
		end
		if (pend_load) begin
			pend_ok_q    <= pend_ok_d;
			pend_fault_q <= pend_fault_d;
			pend_pa_q    <= pend_pa_d;
			pend_size_q  <= pend_size_d;
		end
		if (rsp_load) begin
			rsp_ok_q    <= pend_ok_q;
			rsp_fault_q <= pend_fault_q;
			rsp_pa_q    <= pend_pa_q;
			rsp_size_q  <= pend_size_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.translated       = rsp_ok_q;
	assign rsp.fault_code       = rsp_fault_q;
	assign rsp.physical_address = rsp_pa_q;
	assign rsp.page_size_code   = rsp_size_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.ready)
		else $error("request accepted during the clearing sweep");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ptw_pkg::ST_DONE))
		else $error("response raised outside completion");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp.ready))
		else $error("response register overwritten while full");

	a_read_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |=> state_q == ptw_pkg::ST_WALK)
		else $error("table read issued without a walk step to use it");

endmodule

// ===== hdl/ptw_table.sv =====
// Page-table frame store: one write port, one registered read port and a
// clearing sweep after reset. Depends on ptw_pkg.
module ptw_table #(
	parameter int FRAME_COUNT = ptw_pkg::FRAME_COUNT_DEF,
	parameter int AW          = $clog2(FRAME_COUNT * 512)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptw_pkg::ptw_mem_ctl_t         ctl,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [ptw_pkg::ENTRY_W-1:0]   wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [ptw_pkg::ENTRY_W-1:0]   rd_data,
	output logic                          busy
);

	localparam int DEPTH = FRAME_COUNT * 512;

	logic [ptw_pkg::ENTRY_W-1:0] mem_q [DEPTH];
	logic [ptw_pkg::ENTRY_W-1:0] rd_data_q;
	logic [AW-1:0]               clr_addr_q;
	logic                        clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule
